// ===== hdl/rhc_pkg.sv =====
package rhc_pkg;

    localparam int unsigned QW = 12;  // quotient width, 3840 fits

    localparam logic [14:0] HUE_TURN = 15'd23040;
    localparam logic [14:0] OFS_RED = 15'd0;
    localparam logic [14:0] OFS_GREEN = 15'd7680;
    localparam logic [14:0] OFS_BLUE = 15'd15360;

    typedef struct packed {
        logic        valid;
        logic [19:0] hue_rem;
        logic [19:0] hue_div;
        logic [11:0] hue_quo;
        logic        neg;
        logic [14:0] offset;
        logic        gray;
        logic [19:0] sat_rem;
        logic [19:0] sat_div;
        logic [11:0] sat_quo;
        logic [7:0]  value;
        logic [7:0]  alpha;
    } cell_t;

endpackage

// ===== hdl/rhc_div_cell.sv =====
// one restoring division step for both quotients
module rhc_div_cell #(
    parameter int unsigned BIT = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  rhc_pkg::cell_t d_in,
    output rhc_pkg::cell_t d_out
);

    rhc_pkg::cell_t d_reg;
    rhc_pkg::cell_t d_next;
    logic [39:0] hs;
    logic [39:0] ss;

    always_comb begin
        d_next = d_in;
        hs = {20'd0, d_in.hue_div} << BIT;
        ss = {20'd0, d_in.sat_div} << BIT;
        if ({20'd0, d_in.hue_rem} >= hs) begin
            d_next.hue_rem = d_in.hue_rem - hs[19:0];
            d_next.hue_quo[BIT] = 1'b1;
        end
        if ({20'd0, d_in.sat_rem} >= ss) begin
            d_next.sat_rem = d_in.sat_rem - ss[19:0];
            d_next.sat_quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.valid <= 1'b0;
        end else if (en) begin
            d_reg.valid <= d_next.valid;
        end
        if (en) begin
            d_reg[$bits(rhc_pkg::cell_t)-2:0] <= d_next[$bits(rhc_pkg::cell_t)-2:0];
        end
    end

    assign d_out = d_reg;

endmodule

// ===== hdl/rgb_to_hsv_convert.sv =====
// pipeline: an input transaction passes the front end, 12 divider cells and
// the output stage in order; the divider is a chain of one-bit division cells
// throughput: one pixel per cycle; the chain stalls as a whole while a result
// waits in the output stage and m_ready is low
// reset: synchronous active-low aresetn clears all valid flags
module rgb_to_hsv_convert (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_alpha,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [14:0] m_hue,
    output logic [7:0]  m_saturation,
    output logic [7:0]  m_brightness,
    output logic [7:0]  m_opacity
);

    localparam int unsigned N = rhc_pkg::QW;

    logic en;
    rhc_pkg::cell_t front_reg;
    rhc_pkg::cell_t front_next;
    rhc_pkg::cell_t chain [N+1];
    logic [7:0] mx, mn, dl, df;
    logic [14:0] hsum;
    logic [15:0] hs;
    logic [14:0] hue_reg;
    logic [7:0] sat_reg, val_reg, alp_reg;
    logic valid_reg;

    assign en = !valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        mx = (s_red > s_green) ? s_red : s_green;
        mx = (mx > s_blue) ? mx : s_blue;
        mn = (s_red < s_green) ? s_red : s_green;
        mn = (mn < s_blue) ? mn : s_blue;
        dl = mx - mn;
        front_next = '0;
        front_next.valid = s_valid;
        if (mx == s_red) begin
            front_next.neg = s_green < s_blue;
            df = front_next.neg ? s_blue - s_green : s_green - s_blue;
            front_next.offset = rhc_pkg::OFS_RED;
        end else if (mx == s_green) begin
            front_next.neg = s_blue < s_red;
            df = front_next.neg ? s_red - s_blue : s_blue - s_red;
            front_next.offset = rhc_pkg::OFS_GREEN;
        end else begin
            front_next.neg = s_red < s_green;
            df = front_next.neg ? s_green - s_red : s_red - s_green;
            front_next.offset = rhc_pkg::OFS_BLUE;
        end
        front_next.gray = (dl == 8'd0);
        front_next.hue_rem = 20'(df) * 20'd3840;
        front_next.hue_div = {12'd0, dl};
        front_next.sat_rem = 20'(dl) * 20'd255;
        front_next.sat_div = {12'd0, mx};
        front_next.value = mx;
        front_next.alpha = s_alpha;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg.valid <= 1'b0;
        end else if (en) begin
            front_reg.valid <= front_next.valid;
        end
        if (en) begin
            front_reg[$bits(rhc_pkg::cell_t)-2:0] <= front_next[$bits(rhc_pkg::cell_t)-2:0];
        end
    end

    assign chain[0] = front_reg;

    for (genvar i = 0; i < N; i++) begin : g_cell
        rhc_div_cell #(.BIT(N-1-i)) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (en),
            .d_in   (chain[i]),
            .d_out  (chain[i+1])
        );
    end

    always_comb begin
        hs = chain[N].neg ? {1'b0, chain[N].offset} + 16'(rhc_pkg::HUE_TURN)
                            - {4'd0, chain[N].hue_quo}
                          : {1'b0, chain[N].offset} + {4'd0, chain[N].hue_quo};
        hsum = (hs >= {1'b0, rhc_pkg::HUE_TURN}) ? 15'(hs - {1'b0, rhc_pkg::HUE_TURN})
                                                : hs[14:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= chain[N].valid;
        end
        if (en) begin
            hue_reg <= chain[N].gray ? 15'd0 : hsum;
            sat_reg <= chain[N].gray ? 8'd0 : chain[N].sat_quo[7:0];
            val_reg <= chain[N].value;
            alp_reg <= chain[N].alpha;
        end
    end

    assign m_valid = valid_reg;
    assign m_hue = hue_reg;
    assign m_saturation = sat_reg;
    assign m_brightness = val_reg;
    assign m_opacity = alp_reg;

endmodule
